FILE: rtl/kcmm_pkg.sv
// Package for the key count min/max tracker: sizes, codes, payload structs.
// No dependencies.
package kcmm_pkg;
  localparam int MAX_KEYS   = 64;
  localparam int KEY_CHARS  = 10;
  localparam int COUNT_BITS = 16;
  localparam int KEY_BITS   = 5 * KEY_CHARS;
  localparam int IDX_BITS   = $clog2(MAX_KEYS);
  localparam int TOT_BITS   = $clog2(MAX_KEYS + 1);

  typedef enum logic [1:0] {
    OP_INC = 2'd0,
    OP_DEC = 2'd1,
    OP_RPT = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_DECIDE,
    S_UP,
    S_DOWN,
    S_INS,
    S_DEL,
    S_RDEND,
    S_RDEND2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [49:0] key;
  } in_item_t;

  typedef struct packed {
    logic [49:0] max_key;
    logic [15:0] max_count;
    logic [49:0] min_key;
    logic [15:0] min_count;
    logic        is_empty;
    logic [1:0]  status;
  } out_item_t;
endpackage

FILE: rtl/key_count_min_max_tracker_core.sv
// Top level of the key count min/max tracker.
// Depends on kcmm_pkg.
//
// Usage:
//  - Input: drive in_item and pulse start while busy is low; the
//    transaction is taken at that edge and busy rises the next cycle.
//  - Output: out_valid is high for exactly one cycle with out_item; the
//    receiver cannot stall, so no backpressure exists.
//  - The ordered list (lowest count at slot 0) lives in one synchronous
//    RAM of {key,count} with a registered read port.
//  - Sequence: search reads slots one a cycle, then the move phase
//    walks entries one at a time, each read and then written; then two
//    reads fetch the low and high end. The result strobes in the same
//    cycle that busy falls.
//  - Items are handled one at a time; busy covers the whole item.
//  - Reset clears the fill count and the controller; RAM contents are
//    not cleared since only slots below the count are used.
//  - Moves are done as shifts: the moving entry is held in a register
//    and neighbors slide by one slot, so a read and a write never target
//    the same slot at once.
module key_count_min_max_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kcmm_pkg::in_item_t  in_item,
  output logic                out_valid,
  output kcmm_pkg::out_item_t out_item
);
  import kcmm_pkg::*;

  localparam int EW = KEY_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic [EW-1:0] mem [MAX_KEYS];
  logic [EW-1:0] rd_q;
  logic [IDX_BITS-1:0] raddr, waddr;
  logic we;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  state_t state_r, state_nxt;
  logic [TOT_BITS-1:0] total_r, total_nxt;
  logic [TOT_BITS-1:0] pos_r, pos_nxt;     // scan / move index
  logic [TOT_BITS-1:0] hit_r, hit_nxt;     // found slot
  logic                found_r, found_nxt;
  logic                rvld_r, rvld_nxt;   // rd_q holds slot pos_r-1 in search
  logic [1:0]          op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;   // moving entry count
  logic [1:0]          st_r, st_nxt;
  logic [EW-1:0]       lo_r, lo_nxt;
  logic                ov_r, ov_nxt;
  out_item_t           oi_r, oi_nxt;

  wire [KEY_BITS-1:0]   rk = rd_q[EW-1:COUNT_BITS];
  wire [COUNT_BITS-1:0] rc = rd_q[COUNT_BITS-1:0];
  wire [EW-1:0] mov = {key_r, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
    pos_r <= pos_nxt; hit_r <= hit_nxt; found_r <= found_nxt;
    rvld_r <= rvld_nxt; op_r <= op_nxt; key_r <= key_nxt;
    cnt_r <= cnt_nxt; st_r <= st_nxt; lo_r <= lo_nxt; oi_r <= oi_nxt;
  end

  always_comb begin
    state_nxt = state_r; total_nxt = total_r; pos_nxt = pos_r;
    hit_nxt = hit_r; found_nxt = found_r; rvld_nxt = 1'b0;
    op_nxt = op_r; key_nxt = key_r; cnt_nxt = cnt_r; st_nxt = st_r;
    lo_nxt = lo_r; ov_nxt = 1'b0; oi_nxt = oi_r;
    raddr = pos_r[IDX_BITS-1:0]; waddr = pos_r[IDX_BITS-1:0];
    we = 1'b0; wdata = mov;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_item.operation;
          key_nxt = in_item.key[KEY_BITS-1:0];
          pos_nxt = '0; found_nxt = 1'b0; st_nxt = ST_OK;
          if (in_item.operation == OP_INC || in_item.operation == OP_DEC)
            state_nxt = S_SRCH;
          else
            state_nxt = S_RDEND;
        end
      end
      S_SRCH: begin
        // compare slot pos_r-1 while reading slot pos_r
        if (rvld_r && rk == key_r) begin
          found_nxt = 1'b1; hit_nxt = pos_r - 1'b1; cnt_nxt = rc;
          state_nxt = S_DECIDE;
        end else if (pos_r >= total_r) begin
          state_nxt = S_DECIDE;
        end else begin
          rvld_nxt = 1'b1; pos_nxt = pos_r + 1'b1;
        end
      end
      S_DECIDE: begin
        if (op_r == OP_INC) begin
          if (found_r) begin
            if (cnt_r != CMAX) cnt_nxt = cnt_r + 1'b1;
            pos_nxt = hit_r + 1'b1; state_nxt = S_UP;
          end else if (total_r == TOT_BITS'(MAX_KEYS)) begin
            st_nxt = ST_FULL; state_nxt = S_RDEND;
          end else begin
            cnt_nxt = COUNT_BITS'(1);
            pos_nxt = total_r; state_nxt = S_INS;  // shift all up by one
          end
        end else begin
          if (!found_r) begin
            st_nxt = ST_ABSENT; state_nxt = S_RDEND;
          end else if (cnt_r <= COUNT_BITS'(1)) begin
            pos_nxt = hit_r + 1'b1; state_nxt = S_DEL;
          end else begin
            cnt_nxt = cnt_r - 1'b1; pos_nxt = hit_r; state_nxt = S_DOWN;
          end
        end
        rvld_nxt = 1'b0;
      end
      S_UP: begin
        // pos_r = candidate slot above; read it then shift it down
        if (!rvld_r) begin
          if (pos_r >= total_r) begin
            waddr = IDX_BITS'(pos_r - 1'b1); we = 1'b1; wdata = mov;
            state_nxt = S_RDEND;
          end else begin
            rvld_nxt = 1'b1;
          end
        end else if (cnt_r > rc) begin
          waddr = IDX_BITS'(pos_r - 1'b1); we = 1'b1; wdata = rd_q;
          pos_nxt = pos_r + 1'b1;
        end else begin
          waddr = IDX_BITS'(pos_r - 1'b1); we = 1'b1; wdata = mov;
          state_nxt = S_RDEND;
        end
      end
      S_DOWN: begin
        // pos_r = slot being held; compare with pos_r-1
        raddr = IDX_BITS'(pos_r - 1'b1);
        if (!rvld_r) begin
          if (pos_r == '0) begin
            we = 1'b1; state_nxt = S_RDEND;
          end else begin
            rvld_nxt = 1'b1;
          end
        end else if (cnt_r < rc) begin
          we = 1'b1; wdata = rd_q; pos_nxt = pos_r - 1'b1;
        end else begin
          we = 1'b1; state_nxt = S_RDEND;
        end
      end
      S_INS: begin
        // pos_r = destination; move slot pos_r-1 into it
        raddr = IDX_BITS'(pos_r - 1'b1);
        if (pos_r == '0) begin
          we = 1'b1; total_nxt = total_r + 1'b1; state_nxt = S_RDEND;
        end else if (!rvld_r) begin
          rvld_nxt = 1'b1;
        end else begin
          we = 1'b1; wdata = rd_q; pos_nxt = pos_r - 1'b1;
        end
      end
      S_DEL: begin
        // pos_r = source slot; move into pos_r-1
        if (pos_r >= total_r) begin
          total_nxt = total_r - 1'b1; state_nxt = S_RDEND;
        end else if (!rvld_r) begin
          rvld_nxt = 1'b1;
        end else begin
          waddr = IDX_BITS'(pos_r - 1'b1); we = 1'b1; wdata = rd_q;
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_RDEND: begin
        raddr = '0; state_nxt = S_RDEND2;
      end
      S_RDEND2: begin
        raddr = IDX_BITS'(total_r - 1'b1); lo_nxt = rd_q; state_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
        if (total_r == '0) begin
          oi_nxt = '0; oi_nxt.is_empty = 1'b1;
        end else begin
          oi_nxt.max_key   = 50'(rk);
          oi_nxt.max_count = 16'(rc);
          oi_nxt.min_key   = 50'(lo_r[EW-1:COUNT_BITS]);
          oi_nxt.min_count = 16'(lo_r[COUNT_BITS-1:0]);
          oi_nxt.is_empty  = 1'b0;
        end
        oi_nxt.status = st_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item = oi_r;

`ifndef SYNTH
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_BITS'(MAX_KEYS)) else $error("fill count overflow");
  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == S_IDLE) else $error("result while busy");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (oi_r.is_empty == (total_r == '0))) else $error("empty flag");
`endif
endmodule
